// ----- hdl/cfcr_pkg.sv -----
package cfcr_pkg;

    // One received byte pair
    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
    } pair_t;

    // One frame report
    typedef struct packed {
        logic [1:0]  frame_status;
        logic [7:0]  command_code;
        logic [7:0]  payload_0;
        logic [7:0]  payload_1;
        logic [7:0]  payload_2;
        logic [7:0]  payload_3;
        logic [15:0] computed_sum;
        logic [15:0] received_sum;
    } result_t;

    // Signed store position, wide enough for -4 .. 256
    typedef logic signed [9:0] pos_t;

    // Framing and command bytes
    localparam logic [7:0] CR_BYTE       = 8'h0D;
    localparam logic [7:0] LF_BYTE       = 8'h0A;
    localparam logic [7:0] CMD_CONDITION = 8'h57;
    localparam logic [7:0] CMD_SETTINGS  = 8'h37;
    localparam logic [6:0] INDEX_LIMIT   = 7'd58;

    // Frame status codes
    localparam logic [1:0] STATUS_CONDITION = 2'd0;
    localparam logic [1:0] STATUS_SETTINGS  = 2'd1;
    localparam logic [1:0] STATUS_UNKNOWN   = 2'd2;
    localparam logic [1:0] STATUS_MISMATCH  = 2'd3;

    // Fixed store positions
    localparam pos_t POS_LENGTH  = 10'sd2;
    localparam pos_t POS_CMD     = 10'sd4;
    localparam pos_t POS_PAY_M1  = 10'sd5;
    localparam pos_t POS_SUM_LO  = 10'sd12;
    localparam pos_t POS_SUM_HI  = 10'sd13;
    localparam pos_t POS_COPY_LO = 10'sd15;
    localparam pos_t POS_COPY_HI = 10'sd16;
    localparam pos_t POS_FLAG    = 10'sd17;

    // Values written into the status flag byte
    localparam logic [7:0] FLAG_MATCH    = 8'd1;
    localparam logic [7:0] FLAG_MISMATCH = 8'd2;

    // Sequencer states
    typedef enum logic [16:0] {
        S_IDLE     = 17'b00000000000000001,
        S_WR1      = 17'b00000000000000010,
        S_CNT_RD   = 17'b00000000000000100,
        S_CNT_WAIT = 17'b00000000000001000,
        S_SUM      = 17'b00000000000010000,
        S_RV0      = 17'b00000000000100000,
        S_RV1      = 17'b00000000001000000,
        S_RV2      = 17'b00000000010000000,
        S_W12      = 17'b00000000100000000,
        S_W13      = 17'b00000001000000000,
        S_C0       = 17'b00000010000000000,
        S_C1       = 17'b00000100000000000,
        S_C2       = 17'b00001000000000000,
        S_C3       = 17'b00010000000000000,
        S_W17      = 17'b00100000000000000,
        S_OUT      = 17'b01000000000000000,
        S_EMIT     = 17'b10000000000000000
    } state_t;

endpackage

// ----- hdl/crlf_frame_checksum_receiver.sv -----
// Pair that is stored but does not end a frame: ready again once S_WR1 has written its second byte;
// a dropped pair: ready again the next cycle.
// Frame end: the length byte is read, a one-byte-per-cycle walk sums the checksum bytes,
// the received checksum is read; a mismatch also stores the sum and a checksum copy.
// One pair is worked at a time; a finished report waits in an output register.
// Reset clears the write index, the store valid bits (store reads as zero) and all handshakes.
module crlf_frame_checksum_receiver
    import cfcr_pkg::*;
#(
    parameter int BUF_DEPTH = 64
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pair_valid,
    output logic    pair_ready,
    input  pair_t   pair,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int         AW        = $clog2(BUF_DEPTH);
    localparam pos_t       DEPTH_POS = pos_t'(BUF_DEPTH);
    localparam logic [8:0] DEPTH_CNT = 9'(BUF_DEPTH);

    // One checksum step: add the byte, then fold in the arithmetic shift by two
    function automatic logic [15:0] sum_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] s;
        s = c + {8'h00, b};
        return s ^ 16'($signed(s) >>> 2);
    endfunction

    // Frame store
    logic [7:0]           mem [BUF_DEPTH];
    logic [BUF_DEPTH-1:0] valid_reg;
    logic [7:0]           rd_data_reg;

    // Store port controls
    logic          wr_en;
    pos_t          wr_pos;
    logic [7:0]    wr_data;
    logic          wr_ok;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    pos_t          rd_pos;
    logic          rd_ok;
    logic [AW-1:0] rd_addr;

    // Sequencer and datapath registers
    state_t      state_reg, state_next;
    logic [6:0]  idx_reg, idx_next;
    logic [7:0]  byte_reg, byte_next;
    logic        crlf_reg, crlf_next;
    logic [8:0]  count_reg, count_next;
    logic [8:0]  step_reg, step_next;
    logic        pend_reg, pend_next;
    logic [15:0] sum_reg, sum_next;
    logic [15:0] recv_reg, recv_next;
    logic        match_reg, match_next;
    logic [2:0]  ostep_reg, ostep_next;
    logic [7:0]  pay_reg [5];
    logic [7:0]  pay_next [5];
    logic        result_valid_reg, result_valid_next;
    result_t     result_reg, result_next;

    logic        accept;
    logic        emit;
    pos_t        recv_lo_pos;
    pos_t        recv_hi_pos;
    logic [8:0]  len_count;
    logic [15:0] recv_full;
    logic [1:0]  status;

    assign accept      = pair_valid && pair_ready;
    assign pair_ready  = (state_reg == S_IDLE);
    assign recv_lo_pos = $signed({3'b000, idx_reg}) - 10'sd4;
    assign recv_hi_pos = $signed({3'b000, idx_reg}) - 10'sd3;
    assign len_count   = {1'b0, 8'(rd_data_reg + 8'd4)};
    assign recv_full   = {rd_data_reg, recv_reg[7:0]};
    assign emit        = (state_reg == S_EMIT) && (!result_valid_reg || result_ready);

    assign wr_ok   = (wr_pos >= 10'sd0) && (wr_pos < DEPTH_POS);
    assign wr_addr = wr_pos[AW-1:0];
    assign rd_ok   = (rd_pos >= 10'sd0) && (rd_pos < DEPTH_POS);
    assign rd_addr = rd_pos[AW-1:0];

    // Decode the frame status from the checksum match and the command byte
    always_comb
    begin
        if (!match_reg)
            status = STATUS_MISMATCH;
        else if (pay_reg[0] == CMD_CONDITION)
            status = STATUS_CONDITION;
        else if (pay_reg[0] == CMD_SETTINGS)
            status = STATUS_SETTINGS;
        else
            status = STATUS_UNKNOWN;
    end

    // Sequencer: drive the store port and advance the datapath
    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        byte_next         = byte_reg;
        crlf_next         = crlf_reg;
        count_next        = count_reg;
        step_next         = step_reg;
        pend_next         = pend_reg;
        sum_next          = sum_reg;
        recv_next         = recv_reg;
        match_next        = match_reg;
        ostep_next        = ostep_reg;
        pay_next          = pay_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        wr_en             = 1'b0;
        wr_pos            = POS_FLAG;
        wr_data           = 8'h00;
        rd_en             = 1'b0;
        rd_pos            = POS_LENGTH;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (idx_reg > INDEX_LIMIT)
                    begin
                        // drop the pair and restart the frame
                        idx_next = 7'd0;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_pos     = $signed({3'b000, idx_reg});
                        wr_data    = pair.first_byte;
                        byte_next  = pair.second_byte;
                        crlf_next  = (pair.first_byte == CR_BYTE) &&
                                     (pair.second_byte == LF_BYTE);
                        state_next = S_WR1;
                    end
                end
            end
            S_WR1:
            begin
                wr_en      = 1'b1;
                wr_pos     = $signed({3'b000, idx_reg}) + 10'sd1;
                wr_data    = byte_reg;
                idx_next   = idx_reg + 7'd2;
                state_next = crlf_reg ? S_CNT_RD : S_IDLE;
            end
            S_CNT_RD:
            begin
                rd_en      = 1'b1;
                rd_pos     = POS_LENGTH;
                state_next = S_CNT_WAIT;
            end
            S_CNT_WAIT:
            begin
                // cap the byte count at the store depth
                count_next = (len_count > DEPTH_CNT) ? DEPTH_CNT : len_count;
                step_next  = 9'd0;
                pend_next  = 1'b0;
                sum_next   = 16'h0000;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                // issue one read and fold the previous byte each cycle
                if (step_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    rd_pos    = $signed({1'b0, step_reg});
                    step_next = step_reg + 9'd1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                    sum_next = sum_step(sum_reg, rd_data_reg);
                if ((step_reg == count_reg) && !pend_reg)
                    state_next = S_RV0;
            end
            S_RV0:
            begin
                rd_en      = 1'b1;
                rd_pos     = recv_lo_pos;
                state_next = S_RV1;
            end
            S_RV1:
            begin
                rd_en          = 1'b1;
                rd_pos         = recv_hi_pos;
                recv_next[7:0] = rd_data_reg;
                state_next     = S_RV2;
            end
            S_RV2:
            begin
                // signed compare: a match needs the sign bit clear
                recv_next[15:8] = rd_data_reg;
                match_next      = !sum_reg[15] && (sum_reg == recv_full);
                state_next      = (!sum_reg[15] && (sum_reg == recv_full)) ? S_W17 : S_W12;
            end
            S_W12:
            begin
                wr_en      = 1'b1;
                wr_pos     = POS_SUM_LO;
                wr_data    = sum_reg[7:0];
                state_next = S_W13;
            end
            S_W13:
            begin
                wr_en      = 1'b1;
                wr_pos     = POS_SUM_HI;
                wr_data    = sum_reg[15:8];
                state_next = S_C0;
            end
            S_C0:
            begin
                // reread the checksum word after the sum bytes went in
                rd_en      = 1'b1;
                rd_pos     = recv_lo_pos;
                state_next = S_C1;
            end
            S_C1:
            begin
                wr_en      = 1'b1;
                wr_pos     = POS_COPY_LO;
                wr_data    = rd_data_reg;
                state_next = S_C2;
            end
            S_C2:
            begin
                // read the high byte only once the low copy is in the store
                rd_en      = 1'b1;
                rd_pos     = recv_hi_pos;
                state_next = S_C3;
            end
            S_C3:
            begin
                wr_en      = 1'b1;
                wr_pos     = POS_COPY_HI;
                wr_data    = rd_data_reg;
                state_next = S_W17;
            end
            S_W17:
            begin
                wr_en      = 1'b1;
                wr_pos     = POS_FLAG;
                wr_data    = match_reg ? FLAG_MATCH : FLAG_MISMATCH;
                ostep_next = 3'd0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // read the command byte and the four payload bytes
                if (ostep_reg < 3'd5)
                begin
                    rd_en  = 1'b1;
                    rd_pos = (ostep_reg == 3'd0) ? POS_CMD :
                             POS_PAY_M1 + $signed({7'd0, ostep_reg});
                end
                if (ostep_reg != 3'd0)
                    pay_next[ostep_reg - 3'd1] = rd_data_reg;
                ostep_next = ostep_reg + 3'd1;
                if (ostep_reg == 3'd5)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (emit)
                begin
                    result_next.frame_status = status;
                    result_next.command_code = pay_reg[0];
                    result_next.payload_0    = pay_reg[1];
                    result_next.payload_1    = pay_reg[2];
                    result_next.payload_2    = pay_reg[3];
                    result_next.payload_3    = pay_reg[4];
                    result_next.computed_sum = sum_reg;
                    result_next.received_sum = recv_reg;
                    result_valid_next        = 1'b1;
                    idx_next                 = 7'd0;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            idx_reg          <= 7'd0;
            result_valid_reg <= 1'b0;
            pend_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            result_valid_reg <= result_valid_next;
            pend_reg         <= pend_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        crlf_reg   <= crlf_next;
        count_reg  <= count_next;
        step_reg   <= step_next;
        sum_reg    <= sum_next;
        recv_reg   <= recv_next;
        match_reg  <= match_next;
        ostep_reg  <= ostep_next;
        pay_reg    <= pay_next;
        result_reg <= result_next;
    end

    // Store valid bits: an entry never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (wr_en && wr_ok)
            valid_reg[wr_addr] <= 1'b1;
    end

    // Store array, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_ok)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= (rd_ok && valid_reg[rd_addr]) ? mem[rd_addr] : 8'h00;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
